>>> hw/rtl/pgw_pkg.sv
// Shared types and constants for the four-level page table walker.
package pgw_pkg;

    localparam int MAX_LEVELS  = 5;
    localparam int PAGE_SHIFT  = 12;
    localparam int INDEX_W     = 9;
    localparam int LIN_W       = 48;
    localparam int PHYS_W      = 52;
    localparam int ENTRY_W     = 64;
    localparam int FRAME_W     = PHYS_W - PAGE_SHIFT;
    localparam int PRESENT_BIT = 0;
    localparam int PS_BIT      = 7;
    localparam int RSV_LSB     = 13;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_ENTRY   = 1'b1;

    typedef enum logic [1:0] {
        ST_READ        = 2'd0,
        ST_XLATE       = 2'd1,
        ST_NOT_PRESENT = 2'd2,
        ST_FAULT       = 2'd3
    } t_status;

    typedef struct packed {
        logic              kind;
        logic [LIN_W-1:0]  linear_address;
        logic [ENTRY_W-1:0] entry_data;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [PHYS_W-1:0] entry_address;
        logic [PHYS_W-1:0] physical_address;
    } t_out_item;

    // Classified item as it waits between front and back.
    typedef struct packed {
        logic                  is_entry;
        logic [LIN_W-1:0]      linear_address;
        logic [FRAME_W-1:0]    frame;
        logic                  present;
        logic                  page_size;
        logic [MAX_LEVELS-1:0] rsv_nz;
    } t_cmd;

endpackage

>>> hw/rtl/pgw_front.sv
// Front end: decodes an incoming item into walk command fields.
module pgw_front (
    input  pgw_pkg::t_in_item i_item,
    output pgw_pkg::t_cmd     o_cmd
);

    logic [pgw_pkg::ENTRY_W-1:0] mask;

    always_comb begin
        mask                 = '0;
        o_cmd.is_entry       = (i_item.kind == pgw_pkg::KIND_ENTRY);
        o_cmd.linear_address = i_item.linear_address;
        o_cmd.frame          = i_item.entry_data[pgw_pkg::PHYS_W-1:pgw_pkg::PAGE_SHIFT];
        o_cmd.present        = i_item.entry_data[pgw_pkg::PRESENT_BIT];
        o_cmd.page_size      = i_item.entry_data[pgw_pkg::PS_BIT];
        o_cmd.rsv_nz         = '0;
        // Reserved bits of a large page at each level above the bottom
        for (int l = 1; l < pgw_pkg::MAX_LEVELS; l++) begin
            mask = ((pgw_pkg::ENTRY_W'(1) << (pgw_pkg::INDEX_W * l - 1))
                    - pgw_pkg::ENTRY_W'(1)) << pgw_pkg::RSV_LSB;
            o_cmd.rsv_nz[l] = |(i_item.entry_data & mask);
        end
    end

endmodule

>>> hw/rtl/pgw_queue.sv
// Small register queue between front and back end.
module pgw_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/pgw_back.sv
// Back end: walk state, one level decision per item, output register.
module pgw_back #(
    parameter int LEVELS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [pgw_pkg::PHYS_W-1:0] i_cfg_data,
    input  logic               i_cmd_valid,
    input  pgw_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pgw_pkg::t_out_item o_out_item
);

    localparam int LW    = $clog2(LEVELS);
    localparam int EXT_W = (pgw_pkg::PAGE_SHIFT + pgw_pkg::INDEX_W * LEVELS > pgw_pkg::LIN_W)
                         ? pgw_pkg::PAGE_SHIFT + pgw_pkg::INDEX_W * LEVELS : pgw_pkg::LIN_W;
    localparam logic [LW-1:0] TOP = LW'(LEVELS - 1);

    logic                            r_busy, n_busy;
    logic [LW-1:0]                   r_level, n_level;
    logic [pgw_pkg::LIN_W-1:0]       r_held, n_held;
    logic [pgw_pkg::PHYS_W-1:0]      r_root;
    logic                            r_out_valid;
    pgw_pkg::t_out_item              r_out, n_out;

    logic [EXT_W-1:0]                req_ext, held_ext;
    logic [pgw_pkg::INDEX_W-1:0]     req_idx, next_idx;
    logic [LW-1:0]                   next_level;
    logic [2:0]                      lvl3;
    logic [pgw_pkg::PHYS_W-1:0]      off_mask;
    logic [pgw_pkg::FRAME_W-1:0]     leaf_frame;
    logic                            is_leaf, leaf_fault;

    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign req_ext    = EXT_W'(i_cmd.linear_address);
    assign held_ext   = EXT_W'(r_held);
    assign req_idx    = req_ext[pgw_pkg::PAGE_SHIFT + pgw_pkg::INDEX_W * (LEVELS - 1)
                                +: pgw_pkg::INDEX_W];
    assign next_level = r_level - LW'(1);
    assign lvl3       = 3'(r_level);

    always_comb begin
        next_idx = '0;
        off_mask = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (next_level == LW'(l)) begin
                next_idx = held_ext[pgw_pkg::PAGE_SHIFT + pgw_pkg::INDEX_W * l
                                    +: pgw_pkg::INDEX_W];
            end
            if (r_level == LW'(l)) begin
                off_mask = pgw_pkg::PHYS_W'((64'(1) << (pgw_pkg::PAGE_SHIFT
                           + pgw_pkg::INDEX_W * l)) - 64'(1));
            end
        end
    end

    always_comb begin
        leaf_frame = i_cmd.frame;
        // drop the PAT bit of 2M and 1G pages
        if (lvl3 == 3'd1 || lvl3 == 3'd2) begin
            leaf_frame[0] = 1'b0;
        end
        is_leaf    = (r_level == '0) || i_cmd.page_size;
        leaf_fault = (r_level != '0) && ((r_level == TOP) || i_cmd.rsv_nz[lvl3]);
    end

    always_comb begin
        n_busy  = r_busy;
        n_level = r_level;
        n_held  = r_held;
        n_out   = '{status: pgw_pkg::ST_FAULT, entry_address: '0, physical_address: '0};
        if (!i_cmd.is_entry) begin
            n_busy              = 1'b1;
            n_level             = TOP;
            n_held              = i_cmd.linear_address;
            n_out.status        = pgw_pkg::ST_READ;
            n_out.entry_address = {r_root[pgw_pkg::PHYS_W-1:pgw_pkg::PAGE_SHIFT], req_idx, 3'b000};
        end else if (!r_busy) begin
            n_out.status = pgw_pkg::ST_FAULT;
        end else if (!i_cmd.present) begin
            n_busy       = 1'b0;
            n_level      = TOP;
            n_out.status = pgw_pkg::ST_NOT_PRESENT;
        end else if (is_leaf) begin
            n_busy  = 1'b0;
            n_level = TOP;
            if (leaf_fault) begin
                n_out.status = pgw_pkg::ST_FAULT;
            end else begin
                n_out.status           = pgw_pkg::ST_XLATE;
                n_out.physical_address = {leaf_frame, pgw_pkg::PAGE_SHIFT'(0)}
                                       + (pgw_pkg::PHYS_W'(r_held) & off_mask);
            end
        end else begin
            n_level             = next_level;
            n_out.status        = pgw_pkg::ST_READ;
            n_out.entry_address = {i_cmd.frame, next_idx, 3'b000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_level     <= TOP;
            r_held      <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_root <= i_cfg_data;
            end
            if (o_cmd_pop) begin
                r_busy      <= n_busy;
                r_level     <= n_level;
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/four_level_page_table_walker_top.sv
// Top level of the four-level page table walker.
// Walks an x86-64 style page table one level per item: a translate request gives the read
// address of the top-level entry, and each returned entry gives the next entry address, the
// translated address, not present, or fault. The block takes one item per clock while input
// ready is high and gives one result per item; an accepted item is written into the front
// queue, and the back end then decides it and loads the output register, where the result
// becomes valid. Throughput is set by the back end, which makes one level decision per cycle
// while the output accepts results; when it is stalled the queue fills and input ready
// drops. Write table_root only while idle.
module four_level_page_table_walker_top #(
    parameter int LEVELS      = 4,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pgw_pkg::PHYS_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  pgw_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output pgw_pkg::t_out_item         o_out_item
);

    pgw_pkg::t_cmd front_cmd;
    pgw_pkg::t_cmd q_cmd;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;

    assign o_in_ready = !q_full;

    pgw_front u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd)
    );

    pgw_queue #(
        .W     ($bits(pgw_pkg::t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    pgw_back #(
        .LEVELS (LEVELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
